FILE: design/epoch_seconds_to_calendar_assert.svh
// Assertion macros shared by the design files.
`ifndef EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH
`ifndef SYNTH
`define ESC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define ESC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ESC_ASSERT_IMPL(label, ante, cons, msg)
`define ESC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: design/esc_pkg.sv
`timescale 1ns / 1ps
package esc_pkg;

  localparam int SECONDS_WIDTH_DEF = 40;

  // The rebased count is kept non-negative by adding one 400-year cycle of seconds
  // and taking away the seconds from 1970-01-01 to 2000-03-01.
  localparam logic [63:0] REBASE_OFFSET = 64'd11670912000;
  localparam int ERA_BITS = 33;
  localparam int ERA_DW = 34;
  localparam logic [ERA_DW-1:0] SECS_PER_ERA = 34'd12622780800;

  localparam logic [16:0] SECS_PER_DAY = 17'd86400;
  localparam logic [17:0] DAYS_400Y = 18'd146097;
  localparam logic [15:0] DAYS_100Y = 16'd36524;
  localparam logic [15:0] DAYS_4Y = 16'd1461;
  localparam logic [15:0] DAYS_1Y = 16'd365;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [11:0] SECS_PER_MIN = 12'd60;

  localparam logic [4:0] CENT_CLAMP = 5'd4;
  localparam logic [4:0] QUAD_CLAMP = 5'd25;
  localparam logic [4:0] YRS_CLAMP = 5'd4;
  localparam logic [3:0] LAST_MONTH = 4'd11;
  localparam logic [3:0] MONTHS = 4'd12;
  localparam logic [3:0] MARCH_INDEX = 4'd2;
  localparam logic [9:0] JAN_FEB_DAYS = 10'd59;
  localparam logic [15:0] YEAR_BIAS = 16'd300;
  localparam logic [3:0] WEEK_DAYS = 4'd7;
  localparam logic [3:0] WEEKDAY_BIAS = 4'd3;

  typedef struct packed {
    logic busy;
    logic done;
    logic qbit;
  } div_stat_t;

  // Month lengths of a year that starts in March.
  function automatic logic [4:0] march_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd0: len = 5'd31;
      4'd1: len = 5'd30;
      4'd2: len = 5'd31;
      4'd3: len = 5'd30;
      4'd4: len = 5'd31;
      4'd5: len = 5'd31;
      4'd6: len = 5'd30;
      4'd7: len = 5'd31;
      4'd8: len = 5'd30;
      4'd9: len = 5'd31;
      4'd10: len = 5'd31;
      4'd11: len = 5'd29;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: design/esc_seconds_if.sv
`timescale 1ns / 1ps
interface esc_seconds_if #(
  parameter int SECONDS_WIDTH = esc_pkg::SECONDS_WIDTH_DEF
);
  logic valid;
  logic ready;
  logic [SECONDS_WIDTH-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink (input valid, input epoch_seconds, output ready);
endinterface

FILE: design/esc_calendar_if.sv
`timescale 1ns / 1ps
interface esc_calendar_if;
  logic valid;
  logic ready;
  logic [15:0] year_since_1900;
  logic [3:0] month_index;
  logic [4:0] day_of_month;
  logic [2:0] weekday;
  logic [8:0] day_of_year;
  logic [4:0] hour_of_day;
  logic [5:0] minute_of_hour;
  logic [5:0] second_of_minute;

  modport source (
    output valid, output year_since_1900, output month_index, output day_of_month,
    output weekday, output day_of_year, output hour_of_day, output minute_of_hour,
    output second_of_minute, input ready
  );
  modport sink (
    input valid, input year_since_1900, input month_index, input day_of_month,
    input weekday, input day_of_year, input hour_of_day, input minute_of_hour,
    input second_of_minute, output ready
  );
endinterface

FILE: design/esc_serdiv.sv
`timescale 1ns / 1ps
`include "epoch_seconds_to_calendar_assert.svh"
module esc_serdiv #(
  parameter int NW = 18,
  parameter int QW = 5,
  parameter int DW = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NW-1:0]   dividend,
  input  logic [DW-1:0]   divisor,
  output esc_pkg::div_stat_t stat,
  output logic [QW-1:0]   quotient,
  output logic [DW-1:0]   remainder
);
  import esc_pkg::*;

  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem;
  logic [QW-1:0] shreg;
  logic [DW-1:0] dvsr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          qbit;

  // The dividend bits above the quotient field are known to be below the divisor,
  // so they load straight into the partial remainder.
  always_comb begin
    trial = {rem, shreg[QW-1]};
    diff = trial - {1'b0, dvsr};
    qbit = ~diff[DW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(QW);
        rem <= DW'(dividend >> QW);
        shreg <= dividend[QW-1:0];
        dvsr <= divisor;
      end else if (busy) begin
        rem <= qbit ? diff[DW-1:0] : trial[DW-1:0];
        shreg <= QW'({shreg, qbit});
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.qbit = qbit;
  assign quotient = shreg;
  assign remainder = rem;

  `ESC_ASSERT_IMPL(a_start_idle, start, !busy, "divider restarted while busy")
  `ESC_ASSERT_IMPL(a_rem_bound, done, rem < dvsr, "remainder not below divisor")
  `ESC_ASSERT_NEXT(a_last_step, busy && cnt == CW'(1), done && !busy, "divider did not finish")
endmodule

FILE: design/epoch_seconds_to_calendar.sv
`timescale 1ns / 1ps
// Converts a count of seconds since 1970-01-01 00:00:00 UTC into a Gregorian
// calendar date and time of day.
// The seconds channel carries one count per transaction; the calendar channel
// returns one date and time transaction for each count, in order.
// One count is worked on at a time. The count passes through four bit-serial
// restoring dividers: the 400-year cycle, the day, the century, 4-year and year
// split, and in parallel the hour and minute split. The month is then found by
// walking the month lengths one month per cycle.
// The time from acceptance of the count to the result being valid depends on
// SECONDS_WIDTH and on the month. The next count is accepted in the cycle after
// the previous result has been loaded.
// The result sits in an output register, so a new count is accepted and
// converted while the previous result still waits. If the receiver stalls, the
// finished conversion waits until the output register frees up.
// Reset returns the converter to idle and drops any pending result.
`include "epoch_seconds_to_calendar_assert.svh"
module epoch_seconds_to_calendar #(
  parameter int SECONDS_WIDTH = esc_pkg::SECONDS_WIDTH_DEF
) (
  input logic            clk,
  input logic            rst,
  esc_seconds_if.sink    seconds,
  esc_calendar_if.source calendar
);
  import esc_pkg::*;

  localparam int TW = ((SECONDS_WIDTH > ERA_BITS) ? SECONDS_WIDTH : ERA_BITS) + 1;
  localparam int QE = TW - ERA_BITS;
  localparam logic [TW-1:0] REBASE_TW = TW'(REBASE_OFFSET);
  localparam logic [TW-1:0] SECONDS_MASK = TW'({SECONDS_WIDTH{1'b1}});

  typedef enum logic [2:0] {
    S_IDLE, S_ERA, S_DAY, S_CENT, S_QUAD, S_YRS, S_MONTH, S_FINISH
  } state_t;

  typedef enum logic [1:0] {T_IDLE, T_HOUR, T_MIN, T_DONE} tstate_t;

  state_t  state;
  tstate_t t_state;

  div_stat_t era_stat, day_stat, date_stat, time_stat;
  logic [QE-1:0]     era_quot;
  logic [ERA_DW-1:0] era_rem;
  logic [17:0]       day_quot;
  logic [16:0]       day_rem;
  logic [4:0]        date_quot;
  logic [15:0]       date_rem;
  logic [5:0]        time_quot;
  logic [11:0]       time_rem;

  logic              era_start, day_start, date_start, time_start;
  logic [TW-1:0]     era_dividend;
  logic [17:0]       date_dividend;
  logic [15:0]       date_divisor;
  logic [16:0]       time_dividend;
  logic [11:0]       time_divisor;

  logic [15:0] era_q;
  logic [1:0]  cent;
  logic [4:0]  quad;
  logic [2:0]  wd_acc;
  logic [8:0]  rd_m;
  logic [3:0]  month_cnt;
  logic [8:0]  yday;
  logic [15:0] year_base;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  logic        out_valid;
  logic [15:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_mday;
  logic [2:0]  out_wday;
  logic [8:0]  out_yday;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;

  logic [1:0]  cent_c;
  logic [15:0] rd2;
  logic [4:0]  quad_c;
  logic [10:0] rd3;
  logic [1:0]  yrs_c;
  logic [8:0]  rd4;
  logic        leap;
  logic [9:0]  yday_raw;
  logic [9:0]  year_len;
  logic [15:0] year_calc;
  logic [3:0]  wd_step;
  logic [3:0]  wd_final;
  logic [3:0]  month_raw;
  logic [4:0]  mlen;
  logic        out_load;

  assign era_start = seconds.valid && (state == S_IDLE);
  assign era_dividend = (TW'(seconds.epoch_seconds) & SECONDS_MASK) + REBASE_TW;
  assign day_start = (state == S_ERA) && era_stat.done;
  assign date_start = ((state == S_DAY) && day_stat.done) ||
                      ((state == S_CENT || state == S_QUAD) && date_stat.done);
  assign time_start = ((state == S_DAY) && day_stat.done) ||
                      ((t_state == T_HOUR) && time_stat.done);

  always_comb begin
    cent_c = (date_quot == CENT_CLAMP) ? 2'd3 : date_quot[1:0];
    rd2 = (date_quot == CENT_CLAMP) ? date_rem + DAYS_100Y : date_rem;
    quad_c = (date_quot == QUAD_CLAMP) ? QUAD_CLAMP - 5'd1 : date_quot;
    rd3 = (date_quot == QUAD_CLAMP) ? 11'(date_rem + DAYS_4Y) : date_rem[10:0];
    yrs_c = (date_quot == YRS_CLAMP) ? 2'd3 : date_quot[1:0];
    rd4 = (date_quot == YRS_CLAMP) ? 9'(date_rem + DAYS_1Y) : date_rem[8:0];

    case (state)
      S_DAY: begin
        date_dividend = day_quot;
        date_divisor = DAYS_100Y;
      end
      S_CENT: begin
        date_dividend = 18'(rd2);
        date_divisor = DAYS_4Y;
      end
      S_QUAD: begin
        date_dividend = 18'(rd3);
        date_divisor = DAYS_1Y;
      end
      default: begin
        date_dividend = '0;
        date_divisor = DAYS_1Y;
      end
    endcase

    if (t_state == T_HOUR) begin
      time_dividend = 17'(time_rem);
      time_divisor = SECS_PER_MIN;
    end else begin
      time_dividend = day_rem;
      time_divisor = SECS_PER_HOUR;
    end

    leap = (yrs_c == 2'd0) && (quad != 5'd0 || cent == 2'd0);
    yday_raw = 10'(rd4) + JAN_FEB_DAYS + 10'(leap);
    year_len = 10'(DAYS_1Y) + 10'(leap);
    year_calc = (era_q << 8) + (era_q << 7) + (era_q << 4) + 16'(cent) * 16'd100 +
                (16'(quad) << 2) + 16'(yrs_c) - YEAR_BIAS;

    wd_step = {wd_acc, day_stat.qbit};
    wd_final = {1'b0, wd_acc} + WEEKDAY_BIAS;
    month_raw = month_cnt + MARCH_INDEX;
    mlen = march_len(month_cnt);
    out_load = (state == S_FINISH) && (t_state == T_DONE) && (!out_valid || calendar.ready);
  end

  esc_serdiv #(.NW(TW), .QW(QE), .DW(ERA_DW)) u_era_div (
    .clk(clk), .rst(rst), .start(era_start), .dividend(era_dividend),
    .divisor(SECS_PER_ERA), .stat(era_stat), .quotient(era_quot), .remainder(era_rem)
  );

  esc_serdiv #(.NW(ERA_DW), .QW(18), .DW(17)) u_day_div (
    .clk(clk), .rst(rst), .start(day_start), .dividend(era_rem),
    .divisor(SECS_PER_DAY), .stat(day_stat), .quotient(day_quot), .remainder(day_rem)
  );

  esc_serdiv #(.NW(18), .QW(5), .DW(16)) u_date_div (
    .clk(clk), .rst(rst), .start(date_start), .dividend(date_dividend),
    .divisor(date_divisor), .stat(date_stat), .quotient(date_quot), .remainder(date_rem)
  );

  esc_serdiv #(.NW(17), .QW(6), .DW(12)) u_time_div (
    .clk(clk), .rst(rst), .start(time_start), .dividend(time_dividend),
    .divisor(time_divisor), .stat(time_stat), .quotient(time_quot), .remainder(time_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      t_state <= T_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && calendar.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (seconds.valid) begin
            state <= S_ERA;
            t_state <= T_IDLE;
          end
        end
        S_ERA: begin
          if (era_stat.done) begin
            era_q <= 16'(era_quot);
            wd_acc <= '0;
            state <= S_DAY;
          end
        end
        S_DAY: begin
          if (day_stat.busy) begin
            wd_acc <= (wd_step >= WEEK_DAYS) ? 3'(wd_step - WEEK_DAYS) : wd_step[2:0];
          end
          if (day_stat.done) begin
            t_state <= T_HOUR;
            state <= S_CENT;
          end
        end
        S_CENT: begin
          if (date_stat.done) begin
            cent <= cent_c;
            state <= S_QUAD;
          end
        end
        S_QUAD: begin
          if (date_stat.done) begin
            quad <= quad_c;
            state <= S_YRS;
          end
        end
        S_YRS: begin
          if (date_stat.done) begin
            rd_m <= rd4;
            month_cnt <= '0;
            year_base <= year_calc;
            yday <= (yday_raw >= year_len) ? 9'(yday_raw - year_len) : yday_raw[8:0];
            state <= S_MONTH;
          end
        end
        S_MONTH: begin
          if (month_cnt < LAST_MONTH && 9'(mlen) <= rd_m) begin
            rd_m <= rd_m - 9'(mlen);
            month_cnt <= month_cnt + 4'd1;
          end else begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_load) begin
            out_valid <= 1'b1;
            if (month_raw >= MONTHS) begin
              out_month <= month_raw - MONTHS;
              out_year <= year_base + 16'd1;
            end else begin
              out_month <= month_raw;
              out_year <= year_base;
            end
            out_mday <= 5'(rd_m) + 5'd1;
            out_wday <= (wd_final >= WEEK_DAYS) ? 3'(wd_final - WEEK_DAYS) : wd_final[2:0];
            out_yday <= yday;
            out_hour <= hour;
            out_minute <= minute;
            out_second <= second;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      case (t_state)
        T_HOUR: begin
          if (time_stat.done) begin
            hour <= time_quot[4:0];
            t_state <= T_MIN;
          end
        end
        T_MIN: begin
          if (time_stat.done) begin
            minute <= time_quot;
            second <= time_rem[5:0];
            t_state <= T_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign seconds.ready = (state == S_IDLE);
  assign calendar.valid = out_valid;
  assign calendar.year_since_1900 = out_year;
  assign calendar.month_index = out_month;
  assign calendar.day_of_month = out_mday;
  assign calendar.weekday = out_wday;
  assign calendar.day_of_year = out_yday;
  assign calendar.hour_of_day = out_hour;
  assign calendar.minute_of_hour = out_minute;
  assign calendar.second_of_minute = out_second;

  `ESC_ASSERT_IMPL(a_day_in_era, day_stat.done, day_quot < DAYS_400Y, "day count beyond era")
  `ESC_ASSERT_IMPL(a_cent_bound, (state == S_CENT) && date_stat.done, date_quot <= CENT_CLAMP, "century count too large")
  `ESC_ASSERT_IMPL(a_month_walk, state == S_FINISH, rd_m < 9'(march_len(month_cnt)), "day beyond month length")
endmodule
